[design/skt_pkg.sv]
package skt_pkg;

   // Fixed-point format of positions and variances.
   localparam int FRAC_BITS = 16;

   // Reset values of the configuration registers and of the filter state.
   localparam logic [63:0] MEAS_VAR_FULL  = 64'd2 << FRAC_BITS;
   localparam logic [63:0] PROC_VAR_FULL  = 64'd1 << FRAC_BITS;
   localparam logic [63:0] DRIFT_FULL     = ((64'd1 << FRAC_BITS) + 64'd50) / 64'd100;
   localparam logic [63:0] EST_VAR_FULL   = 64'd400 << FRAC_BITS;
   localparam logic [31:0] MEAS_VAR_RESET = MEAS_VAR_FULL[31:0];
   localparam logic [31:0] PROC_VAR_RESET = PROC_VAR_FULL[31:0];
   localparam logic [31:0] DRIFT_RESET    = DRIFT_FULL[31:0];
   localparam logic [31:0] EST_VAR_RESET  =
      (EST_VAR_FULL > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : EST_VAR_FULL[31:0];

   // Sign bit used to move between two's complement and offset binary.
   localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

   // Register indexes of the configuration port.
   localparam logic [1:0] REG_MEAS_VAR = 2'd0;
   localparam logic [1:0] REG_PROC_VAR = 2'd1;
   localparam logic [1:0] REG_DRIFT    = 2'd2;

   // Widths of the divider operands.
   localparam int NUM_W = 65;
   localparam int DEN_W = 33;
   localparam int QUO_W = 32;

   typedef struct packed {
      logic [31:0] meas_var;
      logic [31:0] proc_var;
      logic [31:0] drift;
   } skt_cfg_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } skt_div_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_Z,
      ST_MUL_P,
      ST_EST_START,
      ST_EST_WAIT,
      ST_MUL_VAR,
      ST_VAR_START,
      ST_VAR_WAIT,
      ST_DONE
   } skt_state_type;

endpackage

[design/skt_csr.sv]
module skt_csr
   import skt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output skt_cfg_type cfg
);

   logic [31:0] meas_var_ff;
   logic [31:0] proc_var_ff;
   logic [31:0] drift_ff;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register writes; an address beyond the register list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         meas_var_ff <= MEAS_VAR_RESET;
         proc_var_ff <= PROC_VAR_RESET;
         drift_ff    <= DRIFT_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            REG_MEAS_VAR: meas_var_ff <= csr_pwdata;
            REG_PROC_VAR: proc_var_ff <= csr_pwdata;
            REG_DRIFT:    drift_ff    <= csr_pwdata;
            default:      ;
         endcase
      end
   end

   // Read data.
   always_comb begin
      case (reg_idx)
         REG_MEAS_VAR: csr_prdata = meas_var_ff;
         REG_PROC_VAR: csr_prdata = proc_var_ff;
         REG_DRIFT:    csr_prdata = drift_ff;
         default:      csr_prdata = 32'd0;
      endcase
   end

   assign cfg.meas_var = meas_var_ff;
   assign cfg.proc_var = proc_var_ff;
   assign cfg.drift    = drift_ff;

endmodule

[design/skt_div.sv]
module skt_div
   import skt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  skt_div_cmd_type  cmd,
   output logic             done,
   output logic [QUO_W-1:0] quotient
);

   // Restoring divider, one quotient bit per cycle. The numerator is known
   // to be below den * 2^QUO_W, so its upper part is a valid first remainder.
   localparam int CNT_W = $clog2(QUO_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUO_W - 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] rem_in;
   logic [QUO_W-1:0] q_ff;
   logic [QUO_W-1:0] q_in;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   shifted;
   logic [DEN_W+1:0] diff;

   // One trial subtraction.
   always_comb begin
      shifted = {rem_ff, q_ff[QUO_W-1]};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      if (!diff[DEN_W+1]) begin
         rem_in = diff[DEN_W-1:0];
      end else begin
         rem_in = shifted[DEN_W-1:0];
      end
      q_in = {q_ff[QUO_W-2:0], ~diff[DEN_W+1]};
   end

   // Step control.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == LAST_STEP);
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Remainder and quotient shift register.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rem_ff <= cmd.num[NUM_W-1:QUO_W];
         q_ff   <= cmd.num[QUO_W-1:0];
         den_ff <= cmd.den;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

[design/scalar_kalman_tracker.sv]
// One-dimensional Kalman filter tracker in signed Q16.16 fixed point.
// The req_ channel carries one position measurement per transaction; each
// one gives exactly one transaction on the rsp_ channel with the predicted
// position and variance and the updated estimate and variance.
// The csr_ port is APB style: measurement variance at 0x0, process variance
// at 0x4, drift per step at 0x8. Write it only while the block is idle.
// Each measurement passes from acceptance to a valid result through three
// passes of one shared 32x32 multiplier and two passes of one shared
// restoring divider (32 quotient bits, one per cycle, then a done strobe),
// with sequencing states around them. A zero denominator skips both
// divisions. A new measurement is taken only once the previous one has
// left the sequencer.
// The result sits in an output register; while the receiver stalls the
// next measurement is still accepted and computed, and it waits at the end
// until the output register is free.
// Synchronous reset restores the register defaults, zeroes the position
// estimate and sets the estimate variance to 400.0.
module scalar_kalman_tracker
   import skt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_measured_position,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_predicted_position,
   output logic        [31:0] rsp_predicted_variance,
   output logic signed [31:0] rsp_estimated_position,
   output logic        [31:0] rsp_estimated_variance,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic        [3:0]  csr_paddr,
   input  logic        [31:0] csr_pwdata,
   output logic        [31:0] csr_prdata,
   output logic               csr_pready
);

   skt_cfg_type     cfg;
   skt_div_cmd_type div_cmd;
   logic            div_done;
   logic [31:0]     div_quo;

   skt_state_type state_ff;
   skt_state_type state_in;

   logic [31:0]      pos_est_ff;
   logic [31:0]      var_est_ff;
   logic [31:0]      p_ff;
   logic [31:0]      pp_ff;
   logic [31:0]      z_ff;
   logic [32:0]      d_ff;
   logic [NUM_W-1:0] acc_ff;
   logic [31:0]      est_ff;
   logic [31:0]      var_ff;

   logic        rsp_valid_ff;
   logic [31:0] rsp_p_ff;
   logic [31:0] rsp_pp_ff;
   logic [31:0] rsp_est_ff;
   logic [31:0] rsp_var_ff;

   logic        req_fire;
   logic        rsp_free;
   logic        div_start;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] product;
   logic [32:0] p_sum;
   logic [31:0] p_sat;
   logic [32:0] pp_sum;
   logic [31:0] pp_sat;
   logic [32:0] d_half;

   skt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign div_cmd.start = div_start;
   assign div_cmd.num   = acc_ff;
   assign div_cmd.den   = d_ff;

   skt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_fire = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign d_half   = {1'b0, d_ff[32:1]};

   // Prediction: saturating signed add and saturating unsigned add.
   always_comb begin
      p_sum = {pos_est_ff[31], pos_est_ff} + {cfg.drift[31], cfg.drift};
      if (p_sum[32] != p_sum[31]) begin
         p_sat = p_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         p_sat = p_sum[31:0];
      end
      pp_sum = {1'b0, var_est_ff} + {1'b0, cfg.proc_var};
      pp_sat = pp_sum[32] ? 32'hFFFF_FFFF : pp_sum[31:0];
   end

   // Shared multiplier; its product is registered in the accumulator.
   assign product = mul_a * mul_b;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_MUL_Z;
         ST_MUL_Z:     state_in = ST_MUL_P;
         ST_MUL_P:     state_in = (d_ff == '0) ? ST_DONE : ST_EST_START;
         ST_EST_START: state_in = ST_EST_WAIT;
         ST_EST_WAIT:  if (div_done) state_in = ST_MUL_VAR;
         ST_MUL_VAR:   state_in = ST_VAR_START;
         ST_VAR_START: state_in = ST_VAR_WAIT;
         ST_VAR_WAIT:  if (div_done) state_in = ST_DONE;
         ST_DONE:      if (rsp_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshake, multiplier operands and divider start.
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      mul_a     = pp_ff;
      mul_b     = z_ff ^ SIGN_BIT;
      case (state_ff)
         ST_IDLE: begin
            // No transaction is taken while reset is held.
            req_ready = !reset;
         end
         ST_MUL_P: begin
            mul_a = cfg.meas_var;
            mul_b = p_ff ^ SIGN_BIT;
         end
         ST_MUL_VAR: begin
            mul_a = pp_ff;
            mul_b = cfg.meas_var;
         end
         ST_EST_START, ST_VAR_START: begin
            div_start = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers of the item in flight.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               p_ff  <= p_sat;
               pp_ff <= pp_sat;
               z_ff  <= req_measured_position;
            end
         end
         ST_MUL_Z: begin
            acc_ff <= {1'b0, product};
            d_ff   <= {1'b0, pp_ff} + {1'b0, cfg.meas_var};
         end
         ST_MUL_P: begin
            acc_ff <= acc_ff + {1'b0, product} + {32'd0, d_half};
            // With no weight on either side the estimate stays at the prediction.
            if (d_ff == '0) begin
               est_ff <= p_ff;
               var_ff <= 32'd0;
            end
         end
         ST_EST_WAIT: begin
            if (div_done) begin
               est_ff <= div_quo ^ SIGN_BIT;
            end
         end
         ST_MUL_VAR: begin
            acc_ff <= {1'b0, product} + {32'd0, d_half};
         end
         ST_VAR_WAIT: begin
            if (div_done) begin
               var_ff <= div_quo;
            end
         end
         default: ;
      endcase
   end

   // Filter state, updated as the result moves to the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_est_ff <= 32'd0;
         var_est_ff <= EST_VAR_RESET;
      end else if (state_ff == ST_DONE && rsp_free) begin
         pos_est_ff <= est_ff;
         var_est_ff <= var_ff;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_p_ff   <= p_ff;
         rsp_pp_ff  <= pp_ff;
         rsp_est_ff <= est_ff;
         rsp_var_ff <= var_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_predicted_position = rsp_p_ff;
   assign rsp_predicted_variance = rsp_pp_ff;
   assign rsp_estimated_position = rsp_est_ff;
   assign rsp_estimated_variance = rsp_var_ff;

endmodule

[verif/scalar_kalman_tracker_tb.sv]
`timescale 1ns / 1ps

module scalar_kalman_tracker_tb;
   import skt_pkg::*;

   // Cycles without any transaction on any port before the run is abandoned.
   localparam int QUIET_LIMIT  = 4000;
   // Length of the long receiver hold-off and the result counts that start it.
   localparam int HOLD_CYCLES  = 800;
   localparam int HOLD_AT_A    = 400;
   localparam int HOLD_AT_B    = 1200;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS  = 235;
   // Register index with no register behind it.
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [31:0] predicted_position;
      logic [31:0] predicted_variance;
      logic [31:0] estimated_position;
      logic [31:0] estimated_variance;
   } track_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_measured_position = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_predicted_position;
   logic        [31:0] rsp_predicted_variance;
   logic signed [31:0] rsp_estimated_position;
   logic        [31:0] rsp_estimated_variance;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic        [3:0]  csr_paddr = '0;
   logic        [31:0] csr_pwdata = '0;
   logic        [31:0] csr_prdata;
   logic               csr_pready;

   // Filter state and register copies of the predictor.
   logic [31:0] track_position = '0;
   logic [31:0] track_variance = EST_VAR_RESET;
   logic [31:0] cfg_meas_var   = MEAS_VAR_RESET;
   logic [31:0] cfg_proc_var   = PROC_VAR_RESET;
   logic [31:0] cfg_drift      = DRIFT_RESET;

   logic [31:0]      measurement_q[$];
   track_result_type expected_tracks_q[$];

   int  items_queued = 0;
   int  measurements_sent = 0;
   int  tracks_checked = 0;
   int  error_count = 0;
   int  settings_count = 0;
   int  position_sat_count = 0;
   int  variance_sat_count = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   int  long_hold = 0;
   int  quiet_cycles = 0;
   bit  pace_mode = 1'b0;

   scalar_kalman_tracker dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_measured_position  (req_measured_position),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_predicted_position (rsp_predicted_position),
      .rsp_predicted_variance (rsp_predicted_variance),
      .rsp_estimated_position (rsp_estimated_position),
      .rsp_estimated_variance (rsp_estimated_variance),
      .csr_psel               (csr_psel),
      .csr_penable            (csr_penable),
      .csr_pwrite             (csr_pwrite),
      .csr_paddr              (csr_paddr),
      .csr_pwdata             (csr_pwdata),
      .csr_prdata             (csr_prdata),
      .csr_pready             (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // One line per mismatch, and a running count of them.
   task automatic report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      error_count++;
   endtask

   // Mostly short gaps, now and then a long one.
   function automatic int draw_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 60);
   endfunction

   // One filter step: predict, then update against measurement z.
   function automatic track_result_type kalman_step(logic [31:0] z);
      logic [32:0]      pos_sum;
      logic [32:0]      var_sum;
      logic [32:0]      den;
      logic [127:0]     prod_a;
      logic [127:0]     prod_b;
      logic [127:0]     num;
      logic [127:0]     quo;
      track_result_type res;
      pos_sum = {track_position[31], track_position} + {cfg_drift[31], cfg_drift};
      if (pos_sum[32] != pos_sum[31]) begin
         res.predicted_position = pos_sum[32] ? SIGN_BIT : ~SIGN_BIT;
         position_sat_count++;
      end else begin
         res.predicted_position = pos_sum[31:0];
      end
      var_sum = {1'b0, track_variance} + {1'b0, cfg_proc_var};
      if (var_sum[32]) begin
         res.predicted_variance = '1;
         variance_sat_count++;
      end else begin
         res.predicted_variance = var_sum[31:0];
      end
      den = {1'b0, res.predicted_variance} + {1'b0, cfg_meas_var};
      if (den == '0) begin
         res.estimated_position = res.predicted_position;
         res.estimated_variance = '0;
      end else begin
         // Weighted mean in offset binary, rounded half up.
         prod_a = {96'd0, res.predicted_variance};
         prod_b = {96'd0, z ^ SIGN_BIT};
         num = prod_a * prod_b;
         prod_a = {96'd0, cfg_meas_var};
         prod_b = {96'd0, res.predicted_position ^ SIGN_BIT};
         num = num + prod_a * prod_b + {96'd0, den[32:1]};
         quo = num / {95'd0, den};
         res.estimated_position = quo[31:0] ^ SIGN_BIT;
         // Posterior variance Pp*R/d, rounded half up.
         prod_a = {96'd0, res.predicted_variance};
         prod_b = {96'd0, cfg_meas_var};
         quo = (prod_a * prod_b + {96'd0, den[32:1]}) / {95'd0, den};
         res.estimated_variance = quo[31:0];
      end
      track_position = res.estimated_position;
      track_variance = res.estimated_variance;
      return res;
   endfunction

   // Sender: presents queued measurements and predicts each one on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            expected_tracks_q.push_back(kalman_step(req_measured_position));
            measurements_sent++;
         end
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (measurement_q.size() > 0) begin
            req_valid <= 1'b1;
            req_measured_position <= measurement_q.pop_front();
            if (pace_mode) begin
               send_gap = draw_gap();
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: checks each result transaction and paces rsp_ready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_tracks_q.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected, estimate %h",
                                         rsp_estimated_position));
            end else begin
               track_result_type want;
               want = expected_tracks_q.pop_front();
               if (rsp_predicted_position !== want.predicted_position) begin
                  report_mismatch($sformatf("predicted_position %h, expected %h",
                                            rsp_predicted_position, want.predicted_position));
               end
               if (rsp_predicted_variance !== want.predicted_variance) begin
                  report_mismatch($sformatf("predicted_variance %h, expected %h",
                                            rsp_predicted_variance, want.predicted_variance));
               end
               if (rsp_estimated_position !== want.estimated_position) begin
                  report_mismatch($sformatf("estimated_position %h, expected %h",
                                            rsp_estimated_position, want.estimated_position));
               end
               if (rsp_estimated_variance !== want.estimated_variance) begin
                  report_mismatch($sformatf("estimated_variance %h, expected %h",
                                            rsp_estimated_variance, want.estimated_variance));
               end
            end
            tracks_checked++;
            // Long hold-off so the block fills up and stalls its input.
            if (tracks_checked == HOLD_AT_A || tracks_checked == HOLD_AT_B) begin
               long_hold = HOLD_CYCLES;
            end else if (pace_mode) begin
               recv_gap = draw_gap();
            end
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (pace_mode && $urandom_range(0, 7) == 0) begin
               recv_gap = draw_gap();
            end
         end
      end
   end

   // Watchdog on cycles in which no transaction happens anywhere.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles", QUIET_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // APB write: setup cycle, then access cycle until pready.
   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         REG_MEAS_VAR: cfg_meas_var = value;
         REG_PROC_VAR: cfg_proc_var = value;
         REG_DRIFT:    cfg_drift    = value;
         default: ;
      endcase
   endtask

   // APB read, compared against the register copy.
   task automatic csr_read_check(logic [1:0] index, logic [31:0] want);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {index, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) begin
         report_mismatch($sformatf("register %0d reads %h, expected %h",
                                   index, csr_prdata, want));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_registers();
      csr_read_check(REG_MEAS_VAR, cfg_meas_var);
      csr_read_check(REG_PROC_VAR, cfg_proc_var);
      csr_read_check(REG_DRIFT, cfg_drift);
   endtask

   // Writes all three registers; only called while nothing is in flight.
   task automatic apply_settings(logic [31:0] meas_var, logic [31:0] proc_var,
                                 logic [31:0] drift);
      csr_write(REG_MEAS_VAR, meas_var);
      csr_write(REG_PROC_VAR, proc_var);
      csr_write(REG_DRIFT, drift);
      check_registers();
      settings_count++;
   endtask

   task automatic queue_measurement(logic [31:0] z);
      measurement_q.push_back(z);
      items_queued++;
   endtask

   task automatic wait_idle();
      while (tracks_checked != items_queued) begin
         @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_variance(bit allow_zero);
      logic [31:0] v;
      case ($urandom_range(0, 4))
         0: v = $urandom_range(1, 255);
         1: v = $urandom_range(32'h0001_0000, 32'h0040_0000);
         2: v = 32'hFFFF_FFFF;
         3: v = allow_zero ? 32'd0 : 32'd1;
         default: v = $urandom;
      endcase
      if (!allow_zero && v == 32'd0) begin
         v = 32'd1;
      end
      return v;
   endfunction

   initial begin
      logic [31:0] target;
      logic [31:0] drift;
      int          roll;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Register defaults after reset, then field extremes on default settings.
      check_registers();
      queue_measurement(32'h0000_0000);
      queue_measurement(32'h7FFF_FFFF);
      queue_measurement(32'h8000_0000);
      queue_measurement(32'h0000_0001);
      queue_measurement(32'hFFFF_FFFF);
      queue_measurement(32'hAAAA_AAAA);
      queue_measurement(32'h5555_5555);
      wait_idle();

      // A write to an unmapped address must leave every register alone.
      csr_write(REG_UNUSED, 32'hDEAD_BEEF);
      check_registers();
      queue_measurement(32'h0001_0000);
      wait_idle();

      // Largest process noise and drift: variance and prediction saturate high.
      apply_settings(32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      repeat (4) queue_measurement(32'h7FFF_FFFF);
      wait_idle();

      // Most negative drift with no process noise: prediction saturates low.
      apply_settings(32'd1, 32'd0, 32'h8000_0000);
      repeat (4) queue_measurement(32'h8000_0000);
      wait_idle();

      // Largest measurement noise: the estimate barely moves.
      apply_settings(32'hFFFF_FFFF, 32'd0, 32'd0);
      repeat (3) queue_measurement($urandom);
      wait_idle();

      // Random phases: a drifting target with noise, plus wild and extreme samples.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 3))
            0: drift = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            1: drift = 32'h7FFF_FFFF;
            2: drift = 32'h8000_0000;
            default: drift = $urandom;
         endcase
         if (phase == 0) begin
            drift = DRIFT_RESET;
            apply_settings(MEAS_VAR_RESET, PROC_VAR_RESET, drift);
         end else begin
            apply_settings(pick_variance(1'b0), pick_variance(1'b1), drift);
         end
         pace_mode = (phase % 4) != 3;
         target = $urandom;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
               target = target + ($urandom_range(0, 32'h0002_0000) - 32'h0001_0000);
               queue_measurement(target + ($urandom_range(0, 32'h0004_0000) - 32'h0002_0000));
            end else if (roll < 88) begin
               queue_measurement($urandom);
            end else begin
               case ($urandom_range(0, 3))
                  0: queue_measurement(32'h7FFF_FFFF - $urandom_range(0, 3));
                  1: queue_measurement(32'h8000_0000 + $urandom_range(0, 3));
                  2: queue_measurement(32'd0);
                  default: queue_measurement(32'hFFFF_FFFF);
               endcase
            end
         end
         wait_idle();
      end

      // Let any stray result show up before closing.
      repeat (100) @(posedge clock);
      $display("Checked %0d results from %0d measurements over %0d register settings.",
               tracks_checked, measurements_sent, settings_count);
      $display("Prediction saturated %0d times, predicted variance %0d times.",
               position_sat_count, variance_sat_count);
      if (error_count == 0 && expected_tracks_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
